// File: hw/rtl/phpd_pkg.sv
// ----------------------------------------------------------------------------
// phpd_pkg
// Shared types and constants of the proximity haptic pulse driver.
// ----------------------------------------------------------------------------
package phpd_pkg;

  localparam int DistW   = 16;
  localparam int TimeW   = 32;
  localparam int QuoW    = 9;                  // quotient stays below 450
  localparam int IvW     = 10;                 // interval up to 500 ms
  localparam int ProdW   = DistW + QuoW;       // (d - imminent) * 450
  localparam int DenShW  = DistW + QuoW - 1;   // divisor aligned to top quotient bit
  localparam int StepW   = 4;
  localparam int DivSteps = QuoW;

  localparam logic [IvW-1:0]   IvMin  = IvW'(50);
  localparam logic [QuoW-1:0]  IvSpan = QuoW'(450);

  // register indexes
  localparam logic [1:0] RegErrorDistance    = 2'd0;
  localparam logic [1:0] RegMaxDistance      = 2'd1;
  localparam logic [1:0] RegImminentDistance = 2'd2;
  localparam logic [1:0] RegDiskInterval     = 2'd3;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             head_detected;
    logic [DistW-1:0] head_distance;
    logic             waist_detected;
    logic [DistW-1:0] waist_distance;
    logic [DistW-1:0] left_distance;
    logic [DistW-1:0] right_distance;
    logic             any_imminent;
  } phpd_in_t;

  typedef struct packed {
    logic head_drive;
    logic left_drive;
    logic right_drive;
    logic disk_drive;
  } phpd_out_t;

  typedef struct packed {
    logic load_in;
    logic mul_load;
    logic mul_sel;     // 0 head distance, 1 nearest waist distance
    logic div_step;
    logic save_head;
    logic commit;
  } phpd_cmd_t;

  typedef struct packed {
    logic div_last;
  } phpd_stat_t;

endpackage

// File: hw/rtl/phpd_ctrl.sv
// ----------------------------------------------------------------------------
// phpd_ctrl
// Sequencer: head interval, waist interval, then state update and result.
// ----------------------------------------------------------------------------
module phpd_ctrl import phpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output phpd_cmd_t  cmd,
  input  phpd_stat_t stat
);

  typedef enum logic [2:0] {
    IDLE,
    MUL_HEAD,
    DIV_HEAD,
    MUL_WAIST,
    DIV_WAIST,
    COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   commit_ok;

  assign commit_ok = (state == COMMIT) && (!out_valid || !out_stall);
  assign in_stall  = (state != IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = MUL_HEAD;
      end
      MUL_HEAD: begin
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = 1'b0;
        state_next   = DIV_HEAD;
      end
      DIV_HEAD: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = MUL_WAIST;
      end
      MUL_WAIST: begin
        cmd.save_head = 1'b1;
        cmd.mul_load  = 1'b1;
        cmd.mul_sel   = 1'b1;
        state_next    = DIV_WAIST;
      end
      DIV_WAIST: begin
        cmd.div_step = 1'b1;
        cmd.mul_sel  = 1'b1;
        if (stat.div_last) state_next = COMMIT;
      end
      COMMIT: begin
        cmd.mul_sel = 1'b1;
        cmd.commit  = commit_ok;
        if (commit_ok) state_next = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_ok) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/phpd_dp.sv
// ----------------------------------------------------------------------------
// phpd_dp
// Datapath: config registers, interval mapping with a shared multiply and
// restoring divider, drive phase state and the result register.
// ----------------------------------------------------------------------------
module phpd_dp import phpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [DistW-1:0] cfg_data,
  input  phpd_in_t         in_data,
  output phpd_out_t        out_data,
  input  phpd_cmd_t        cmd,
  output phpd_stat_t       stat
);

  logic [DistW-1:0] error_distance;
  logic [DistW-1:0] max_distance;
  logic [DistW-1:0] imminent_distance;
  logic [DistW-1:0] disk_interval;

  phpd_in_t          in_reg;
  logic [ProdW-1:0]  rem;
  logic [DenShW-1:0] den_sh;
  logic [QuoW-1:0]   quo;
  logic [StepW-1:0]  step;
  logic [IvW-1:0]    head_iv;
  logic              head_on;

  logic             head_phase;
  logic [TimeW-1:0] head_last_toggle;
  logic             waist_phase;
  logic [TimeW-1:0] waist_last_toggle;
  logic             left_level;
  logic             right_level;
  logic             disk_phase;
  logic [TimeW-1:0] disk_last_toggle;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      error_distance    <= DistW'(65535);
      max_distance      <= DistW'(4000);
      imminent_distance <= DistW'(200);
      disk_interval     <= DistW'(100);
    end else if (cfg_write) begin
      case (cfg_index)
        RegErrorDistance:    error_distance    <= cfg_data;
        RegMaxDistance:      max_distance      <= cfg_data;
        RegImminentDistance: imminent_distance <= cfg_data;
        RegDiskInterval:     disk_interval     <= cfg_data;
        default: ;
      endcase
    end
  end

  // nearest of front, left and right
  logic             front_ok, left_ok, right_ok;
  logic [DistW-1:0] near0, near1, nearest;

  always_comb begin
    front_ok = in_reg.waist_detected && (in_reg.waist_distance != error_distance);
    left_ok  = (in_reg.left_distance != error_distance);
    right_ok = (in_reg.right_distance != error_distance);
    near0    = front_ok ? in_reg.waist_distance : error_distance;
    near1    = (left_ok && in_reg.left_distance < near0) ? in_reg.left_distance : near0;
    nearest  = (right_ok && in_reg.right_distance < near1) ? in_reg.right_distance : near1;
  end

  // interval mapping
  logic             fast;
  logic             head_ok, waist_ok;
  logic [DistW-1:0] dist_sel, clamp, diff, den;
  logic [ProdW-1:0] prod;
  logic             take;
  logic [IvW-1:0]   iv_calc;

  always_comb begin
    fast     = (imminent_distance >= max_distance);
    head_ok  = in_reg.head_detected && (in_reg.head_distance < error_distance)
               && (in_reg.head_distance < max_distance);
    waist_ok = (nearest < error_distance) && (nearest < max_distance);
    dist_sel = cmd.mul_sel ? nearest : in_reg.head_distance;
    clamp    = (dist_sel < imminent_distance) ? imminent_distance : dist_sel;
    diff     = clamp - imminent_distance;
    den      = max_distance - imminent_distance;
    prod     = ProdW'(diff) * ProdW'(IvSpan);
    take     = (rem >= {1'b0, den_sh});
    iv_calc  = fast ? IvMin : IvMin + {1'b0, quo};
  end

  assign stat.div_last = (step == StepW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_reg <= in_data;
    if (cmd.mul_load) begin
      rem    <= prod;
      den_sh <= {den, {(QuoW-1){1'b0}}};
      quo    <= '0;
      step   <= '0;
    end else if (cmd.div_step) begin
      if (take) rem <= rem - {1'b0, den_sh};
      den_sh <= den_sh >> 1;
      quo    <= {quo[QuoW-2:0], take};
      step   <= step + StepW'(1);
    end
    if (cmd.save_head) begin
      head_iv <= iv_calc;
      head_on <= head_ok;
    end
  end

  // state update
  logic             head_phase_next, waist_phase_next;
  logic             left_level_next, right_level_next, disk_phase_next;
  logic [TimeW-1:0] head_last_next, waist_last_next, disk_last_next;
  logic [TimeW-1:0] head_el, waist_el, disk_el;

  always_comb begin
    head_el  = in_reg.now_ms - head_last_toggle;
    waist_el = in_reg.now_ms - waist_last_toggle;
    disk_el  = in_reg.now_ms - disk_last_toggle;

    head_phase_next = head_phase;
    head_last_next  = head_last_toggle;
    if (!head_on) begin
      head_phase_next = 1'b0;
    end else if (head_el >= TimeW'(head_iv)) begin
      head_phase_next = ~head_phase;
      head_last_next  = in_reg.now_ms;
    end

    waist_phase_next = waist_phase;
    waist_last_next  = waist_last_toggle;
    left_level_next  = left_level;
    right_level_next = right_level;
    if (!waist_ok) begin
      waist_phase_next = 1'b0;
      left_level_next  = 1'b0;
      right_level_next = 1'b0;
    end else if (waist_el >= TimeW'(iv_calc)) begin
      waist_phase_next = ~waist_phase;
      waist_last_next  = in_reg.now_ms;
      if (front_ok && nearest == in_reg.waist_distance) begin
        left_level_next  = ~waist_phase;
        right_level_next = ~waist_phase;
      end else if (left_ok && (!right_ok || in_reg.left_distance <= in_reg.right_distance)) begin
        left_level_next  = ~waist_phase;
        right_level_next = 1'b0;
      end else if (right_ok) begin
        left_level_next  = 1'b0;
        right_level_next = ~waist_phase;
      end
    end

    disk_phase_next = disk_phase;
    disk_last_next  = disk_last_toggle;
    if (!in_reg.any_imminent) begin
      disk_phase_next = 1'b0;
    end else if (disk_el > TimeW'(disk_interval)) begin
      disk_phase_next = ~disk_phase;
      disk_last_next  = in_reg.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_phase        <= 1'b0;
      head_last_toggle  <= '0;
      waist_phase       <= 1'b0;
      waist_last_toggle <= '0;
      left_level        <= 1'b0;
      right_level       <= 1'b0;
      disk_phase        <= 1'b0;
      disk_last_toggle  <= '0;
    end else if (cmd.commit) begin
      head_phase        <= head_phase_next;
      head_last_toggle  <= head_last_next;
      waist_phase       <= waist_phase_next;
      waist_last_toggle <= waist_last_next;
      left_level        <= left_level_next;
      right_level       <= right_level_next;
      disk_phase        <= disk_phase_next;
      disk_last_toggle  <= disk_last_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.head_drive  <= head_phase_next;
      out_data.left_drive  <= left_level_next;
      out_data.right_drive <= right_level_next;
      out_data.disk_drive  <= disk_phase_next;
    end
  end

endmodule

// File: hw/rtl/proximity_haptic_pulse_driver.sv
// A request is held off while one is in progress: the sequencer loads it, then
// runs two 9-step passes of the shared restoring divider (head interval, then
// waist interval) and commits the result.
// The result register lets the next request in while a result waits.
// Reset (rst, synchronous): drive state and timestamps clear, config
// registers return to 65535 / 4000 / 200 / 100, no result is pending.
// ----------------------------------------------------------------------------
// proximity_haptic_pulse_driver
// Maps sensor distances to blink intervals and toggles four haptic drives.
// ----------------------------------------------------------------------------
module proximity_haptic_pulse_driver import phpd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [DistW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  phpd_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output phpd_out_t        out_data
);

  phpd_cmd_t  cmd;
  phpd_stat_t stat;

  phpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  phpd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTH
  // an accepted request keeps the input side busy
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after accept");

  // a new result only comes out of work in progress
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

  // divider steps and result commit never overlap with an input load
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |-> !cmd.div_step && !cmd.commit && !cmd.mul_load)
    else $error("input load during busy sequence");
`endif

endmodule

// File: bench/proximity_haptic_pulse_driver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity_haptic_pulse_driver_tb
// Drives sensor update requests through the haptic pulse driver and checks
// every drive result against a cycle-free model of the blink logic, across
// several register settings and random idling on both channels.
// ----------------------------------------------------------------------------
module proximity_haptic_pulse_driver_tb import phpd_pkg::*; ();

  localparam int unsigned FastestMs     = 50;
  localparam int unsigned SpanMs        = 450;
  localparam int          QuietLimit    = 2000;
  localparam int          SettleCycles  = 44;
  localparam int          SegmentCount  = 6;
  localparam int          SegmentItems  = 225;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = RegErrorDistance;
  logic [DistW-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  phpd_in_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  phpd_out_t  out_data;

  proximity_haptic_pulse_driver i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // register copies, reset values
  logic [15:0] err_code       = 16'd65535;
  logic [15:0] max_mm         = 16'd4000;
  logic [15:0] near_mm        = 16'd200;
  logic [15:0] disk_period_ms = 16'd100;

  // drive state
  logic        head_phase  = 1'b0;
  logic [31:0] head_mark   = '0;
  logic        waist_phase = 1'b0;
  logic [31:0] waist_mark  = '0;
  logic        left_level  = 1'b0;
  logic        right_level = 1'b0;
  logic        disk_phase  = 1'b0;
  logic [31:0] disk_mark   = '0;

  phpd_in_t  pending_updates[$];
  phpd_out_t expected_drives[$];

  int          send_idle_pct = 22;
  int          recv_idle_pct = 60;
  int          failures = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms = '0;

  function automatic int unsigned blink_interval(input logic [15:0] d);
    int unsigned c;
    if (d >= err_code || d >= max_mm) return 0;
    if (near_mm >= max_mm) return FastestMs;
    c = (d < near_mm) ? near_mm : d;
    return FastestMs + (c - near_mm) * SpanMs / (max_mm - near_mm);
  endfunction

  task automatic predict_update(input phpd_in_t u);
    int unsigned iv;
    logic [15:0] nearest;
    logic [31:0] lapse;
    bit          front_ok, left_ok, right_ok;
    phpd_out_t   drv;
    iv = 0;
    if (u.head_detected && u.head_distance != err_code) iv = blink_interval(u.head_distance);
    lapse = u.now_ms - head_mark;
    if (iv == 0) begin
      head_phase = 1'b0;
    end else if (lapse >= iv) begin
      head_mark = u.now_ms;
      head_phase = ~head_phase;
    end

    nearest = err_code;
    front_ok = 0;
    left_ok = 0;
    right_ok = 0;
    if (u.waist_detected && u.waist_distance != err_code) begin
      nearest = u.waist_distance;
      front_ok = 1;
    end
    if (u.left_distance != err_code) begin
      if (u.left_distance < nearest) nearest = u.left_distance;
      left_ok = 1;
    end
    if (u.right_distance != err_code) begin
      if (u.right_distance < nearest) nearest = u.right_distance;
      right_ok = 1;
    end
    iv = blink_interval(nearest);
    lapse = u.now_ms - waist_mark;
    if (iv == 0) begin
      waist_phase = 1'b0;
      left_level = 1'b0;
      right_level = 1'b0;
    end else if (lapse >= iv) begin
      waist_mark = u.now_ms;
      waist_phase = ~waist_phase;
      // front wins when it is the nearest, else the nearer side, left on a tie
      if (front_ok && nearest == u.waist_distance) begin
        left_level = waist_phase;
        right_level = waist_phase;
      end else if (left_ok && (!right_ok || u.left_distance <= u.right_distance)) begin
        left_level = waist_phase;
        right_level = 1'b0;
      end else if (right_ok) begin
        left_level = 1'b0;
        right_level = waist_phase;
      end
    end

    lapse = u.now_ms - disk_mark;
    if (u.any_imminent) begin
      if (lapse > disk_period_ms) begin
        disk_phase = ~disk_phase;
        disk_mark = u.now_ms;
      end
    end else begin
      disk_phase = 1'b0;
    end

    drv.head_drive = head_phase;
    drv.left_drive = left_level;
    drv.right_drive = right_level;
    drv.disk_drive = disk_phase;
    expected_drives.push_back(drv);
  endtask

  task automatic check_drive(input string field, input logic want, input logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0b, actual %0b", field, want, got);
      failures++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_update(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_updates.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_updates.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    phpd_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $error("result with no request outstanding: %b", out_data);
          failures++;
        end else begin
          want = expected_drives.pop_front();
          check_drive("head_drive", want.head_drive, out_data.head_drive);
          check_drive("left_drive", want.left_drive, out_data.left_drive);
          check_drive("right_drive", want.right_drive, out_data.right_drive);
          check_drive("disk_drive", want.disk_drive, out_data.disk_drive);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic configure(input logic [15:0] err, input logic [15:0] maxd,
                           input logic [15:0] neard, input logic [15:0] diskp);
    put_reg(RegErrorDistance, err);
    put_reg(RegMaxDistance, maxd);
    put_reg(RegImminentDistance, neard);
    put_reg(RegDiskInterval, diskp);
    @(posedge clk);
    cfg_write <= 1'b0;
    err_code = err;
    max_mm = maxd;
    near_mm = neard;
    disk_period_ms = diskp;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_updates.size() != 0 || in_valid || expected_drives.size() != 0);
  endtask

  function automatic phpd_in_t mk_update(input logic [31:0] now, input logic hd,
                                         input logic [15:0] hdist, input logic wd,
                                         input logic [15:0] wdist, input logic [15:0] ldist,
                                         input logic [15:0] rdist, input logic imm);
    phpd_in_t u;
    u.now_ms = now;
    u.head_detected = hd;
    u.head_distance = hdist;
    u.waist_detected = wd;
    u.waist_distance = wdist;
    u.left_distance = ldist;
    u.right_distance = rdist;
    u.any_imminent = imm;
    return u;
  endfunction

  function automatic logic [15:0] pick_distance();
    int unsigned roll, hi;
    roll = $urandom_range(99);
    hi = max_mm + max_mm / 4 + 16;
    if (hi > 65535) hi = 65535;
    if (roll < 8) return 16'd0;
    if (roll < 18) return err_code;
    if (roll < 26) return 16'(max_mm + $urandom_range(2) - 1);
    if (roll < 34) return 16'(near_mm + $urandom_range(2) - 1);
    if (roll < 80) return 16'($urandom_range(hi));
    if (roll < 94) return 16'($urandom_range(65535));
    return 16'(65535 - $urandom_range(3));
  endfunction

  task automatic queue_random(input int count);
    phpd_in_t    u;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      // mostly short steps so intervals elapse now and then, a few wraps and jumps
      if (roll < 70) clock_ms += $urandom_range(120);
      else if (roll < 88) clock_ms += $urandom_range(700, 100);
      else if (roll < 95) clock_ms += $urandom_range(70000);
      else if (roll < 98) clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
      else clock_ms = $urandom();
      u.now_ms = clock_ms;
      u.head_detected = ($urandom_range(99) < 80);
      u.head_distance = pick_distance();
      u.waist_detected = ($urandom_range(99) < 75);
      u.waist_distance = pick_distance();
      u.left_distance = pick_distance();
      u.right_distance = pick_distance();
      if ($urandom_range(99) < 15) u.right_distance = u.left_distance;
      if ($urandom_range(99) < 10) begin
        u.waist_distance = $urandom_range(1) ? u.left_distance : u.right_distance;
      end
      u.any_imminent = 1'($urandom_range(1));
      pending_updates.push_back(u);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values: clamp below imminent, exact interval edge, ties,
    // max and error codes, detect flags off, time wrap, all-ones fields
    pending_updates.push_back(mk_update(32'd0, 1, 16'd0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
    pending_updates.push_back(mk_update(32'd50, 1, 16'd0, 1, 16'd0, 16'hFFFF, 16'hFFFF, 1));
    pending_updates.push_back(mk_update(32'd101, 1, 16'd200, 1, 16'd199, 16'd150, 16'd150, 1));
    pending_updates.push_back(mk_update(32'd200, 1, 16'd3999, 0, 16'd300, 16'd3999, 16'd150,
                                        0));
    pending_updates.push_back(mk_update(32'd700, 1, 16'd3999, 1, 16'd150, 16'd150, 16'd151, 1));
    pending_updates.push_back(mk_update(32'd1300, 1, 16'd4000, 1, 16'd4000, 16'd4000, 16'd3999,
                                        1));
    pending_updates.push_back(mk_update(32'd1900, 1, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        0));
    pending_updates.push_back(mk_update(32'd1901, 0, 16'd100, 0, 16'd100, 16'd5000, 16'd65534,
                                        1));
    pending_updates.push_back(mk_update(32'd2500, 1, 16'd1000, 1, 16'd2000, 16'd900, 16'd800,
                                        1));
    pending_updates.push_back(mk_update(32'd3100, 1, 16'd1000, 1, 16'd2000, 16'd700, 16'd800,
                                        1));
    pending_updates.push_back(mk_update(32'hFFFF_FF00, 1, 16'd200, 1, 16'd200, 16'hFFFF,
                                        16'hFFFF, 1));
    pending_updates.push_back(mk_update(32'hFFFF_FFF0, 1, 16'd200, 1, 16'd200, 16'hFFFF,
                                        16'hFFFF, 1));
    pending_updates.push_back(mk_update(32'h0000_0020, 1, 16'd200, 1, 16'd200, 16'hFFFF,
                                        16'hFFFF, 1));
    pending_updates.push_back(mk_update(32'hFFFF_FFFF, 1, 16'hFFFE, 1, 16'hFFFE, 16'hFFFE,
                                        16'hFFFE, 1));
    pending_updates.push_back(mk_update(32'hFFFF_FFFF, 1, 16'd0, 1, 16'd0, 16'd0, 16'd0, 1));
    pending_updates.push_back(mk_update(32'h5555_AAAA, 1, 16'h5555, 1, 16'hAAAA, 16'h0AAA,
                                        16'h0555, 0));
    pending_updates.push_back(mk_update(32'hAAAA_5555, 0, 16'hAAAA, 0, 16'h5555, 16'h0555,
                                        16'h0AAA, 1));
    clock_ms = 32'hAAAA_5555;
    // sender holds off until every result of this request set is back
    wait_drained();

    for (int seg = 0; seg < SegmentCount; seg++) begin
      case (seg)
        0: configure(16'd65535, 16'd4000, 16'd200, 16'd100);
        1: configure(16'd65535, 16'd65535, 16'd0, 16'd0);
        2: begin
          send_idle_pct = 60;
          recv_idle_pct = 22;
          configure(16'd3000, 16'd5000, 16'd300, 16'd65535);
        end
        3: configure(16'd900, 16'd1000, 16'd1200, 16'd7);
        4: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          configure(16'd65535, 16'd65535, 16'd65534, 16'd1000);
        end
        default: configure(16'd0, 16'd1, 16'd0, 16'd30);
      endcase
      queue_random(SegmentItems);
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk);
    if (failures == 0 && expected_drives.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
